/* src/assert_macros.svh */
// assertion macros shared by the matrix inverse rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MI4_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mi4 assertion failed");
`define MI4_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("mi4 assertion failed");
`else
`define MI4_ASSERT(lbl, clk, rst_n, prop)
`define MI4_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* src/mi4_pkg.sv */
// types, constants and schedule tables for the 4x4 matrix inverse
// no dependencies
package mi4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int AW            = 100;  // accumulator and determinant width
    localparam int QW            = 34;   // quotient bits kept before saturation
    localparam int DVW           = 136;  // divider remainder width
    localparam int JQ_DEPTH      = 2;

    localparam logic CFG_EPSILON = 1'b0;
    localparam logic CFG_FILL    = 1'b1;

    typedef logic [3:0][3:0][ELEM_W-1:0] t_mat;

    typedef struct packed {
        logic push;
        t_mat job;
    } t_jobq_wr;

    typedef enum logic [1:0] {
        K_MINOR = 2'd0,
        K_COF   = 2'd1,
        K_DET   = 2'd2
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic       hi;
        logic       neg;
        t_kind      kind;
        logic [3:0] didx;
    } t_mac_ctl;

    typedef struct packed {
        logic [1:0] erow;
        logic [2:0] midx;
        logic       neg;
    } t_cof_term;

    // row pair of each 2x2 minor: s01 s02 s03 s12 s13 s23
    function automatic logic [3:0] minor_pair(input logic [2:0] idx);
        logic [3:0] p;
        case (idx)
            3'd0:    p = {2'd0, 2'd1};
            3'd1:    p = {2'd0, 2'd2};
            3'd2:    p = {2'd0, 2'd3};
            3'd3:    p = {2'd1, 2'd2};
            3'd4:    p = {2'd1, 2'd3};
            3'd5:    p = {2'd2, 2'd3};
            default: p = {2'd0, 2'd1};
        endcase
        return p;
    endfunction

    // three terms of each cofactor; the other half of a phase negates all signs
    function automatic t_cof_term cof_term(input logic [1:0] k, input logic [1:0] t);
        t_cof_term r;
        case ({k, t})
            4'b00_00: r = '{erow: 2'd0, midx: 3'd3, neg: 1'b0};
            4'b00_01: r = '{erow: 2'd1, midx: 3'd1, neg: 1'b1};
            4'b00_10: r = '{erow: 2'd2, midx: 3'd0, neg: 1'b0};
            4'b01_00: r = '{erow: 2'd1, midx: 3'd2, neg: 1'b0};
            4'b01_01: r = '{erow: 2'd3, midx: 3'd0, neg: 1'b1};
            4'b01_10: r = '{erow: 2'd0, midx: 3'd4, neg: 1'b1};
            4'b10_00: r = '{erow: 2'd0, midx: 3'd5, neg: 1'b0};
            4'b10_01: r = '{erow: 2'd2, midx: 3'd2, neg: 1'b1};
            4'b10_10: r = '{erow: 2'd3, midx: 3'd1, neg: 1'b0};
            4'b11_00: r = '{erow: 2'd2, midx: 3'd4, neg: 1'b0};
            4'b11_01: r = '{erow: 2'd3, midx: 3'd3, neg: 1'b1};
            4'b11_10: r = '{erow: 2'd1, midx: 3'd5, neg: 1'b1};
            default:  r = '{erow: 2'd0, midx: 3'd0, neg: 1'b0};
        endcase
        return r;
    endfunction

endpackage

/* src/mi4_front.sv */
// front end: takes rows, keeps the matrix store, hands complete matrices on
// depends on mi4_pkg
module mi4_front (
    input  logic                        i_clk,
    input  logic                        i_push,
    input  logic                        i_q_full,
    input  logic [1:0]                  i_row_index,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem0,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem1,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem2,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem3,
    input  logic                        i_last_row,
    output logic                        o_full,
    output mi4_pkg::t_jobq_wr           o_wr
);
    import mi4_pkg::*;

    t_mat r_store;
    t_mat n_store;
    logic accept;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        n_store = r_store;
        n_store[i_row_index] = {i_elem3, i_elem2, i_elem1, i_elem0};
    end

    // the job carries the row of this item merged in
    assign o_wr.push = accept && i_last_row;
    assign o_wr.job  = n_store;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store <= n_store;
        end
    end

endmodule

/* src/mi4_jobq.sv */
// short queue of complete matrices between front and back
// depends on mi4_pkg
module mi4_jobq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mi4_pkg::t_jobq_wr i_wr,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output mi4_pkg::t_mat     o_head
);
    import mi4_pkg::*;

    localparam int PW = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
    localparam int CW = $clog2(JQ_DEPTH + 1);

    t_mat          r_mem [JQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(JQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(JQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wr.job;
        end
    end

endmodule

/* src/mi4_back.sv */
// back end: minors, cofactors and determinant on one shared multiplier,
// restoring divider, result register; depends on mi4_pkg
module mi4_back #(
    parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_wdata,
    input  logic                        i_q_empty,
    input  mi4_pkg::t_mat               i_job,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [1:0]                  o_out_row,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv0,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv1,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv2,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv3,
    output logic [mi4_pkg::ELEM_W-1:0]  o_determinant,
    output logic                        o_singular,
    output logic                        o_last
);
    import mi4_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_MINOR  = 11'b000_0000_0010,
        S_COF    = 11'b000_0000_0100,
        S_DET    = 11'b000_0000_1000,
        S_DRAIN  = 11'b000_0001_0000,
        S_CHECK  = 11'b000_0010_0000,
        S_DECIDE = 11'b000_0100_0000,
        S_DIVLD  = 11'b000_1000_0000,
        S_DIV    = 11'b001_0000_0000,
        S_DIVWB  = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    // config
    logic [30:0] r_eps;
    logic [31:0] r_fill;

    // control
    t_state     r_state;
    t_state     r_ret;
    logic       r_phase;
    logic [2:0] r_idx;
    logic [1:0] r_term;
    logic       r_part;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic [5:0] r_it;
    t_mac_ctl   r_ctl1;
    t_mac_ctl   r_ctl2;
    logic       r_ovalid;

    // datapath
    logic [63:0]            r_minor [6];
    logic [63:0]            r_cof [16];
    logic signed [64:0]     r_prod;
    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   r_det;
    logic [AW-1:0]          r_dmag;
    logic                   r_dneg;
    logic [31:0]            r_detf;
    logic                   r_sing;
    logic [DVW-1:0]         r_rem;
    logic [DVW-1:0]         r_dsh;
    logic [QW-1:0]          r_q;
    logic                   r_qneg;
    logic [31:0]            r_rowv [4];
    logic [1:0]             r_orow;
    logic [31:0]            r_ov [4];
    logic [31:0]            r_odet;
    logic                   r_osing;
    logic                   r_olast;

    // issue stage
    t_mac_ctl           ctl0;
    logic signed [31:0] a_op;
    logic signed [32:0] b_op;
    logic [63:0]        bw;
    logic [3:0]         cof_addr;
    logic [63:0]        cof_rd;
    logic [3:0]         pair;
    logic [1:0]         ri;
    logic [1:0]         rj;
    t_cof_term          term;
    logic               h;
    logic [1:0]         k;
    logic [1:0]         ecol;
    logic [1:0]         dcol;

    always_comb begin
        ctl0     = '0;
        a_op     = '0;
        b_op     = '0;
        bw       = '0;
        cof_addr = {r_col, r_row};
        pair     = minor_pair(r_idx);
        ri       = r_part ? pair[1:0] : pair[3:2];
        rj       = r_part ? pair[3:2] : pair[1:0];
        term     = cof_term(r_idx[1:0], r_term);
        h        = r_idx[2];
        k        = r_idx[1:0];
        ecol     = r_phase ? {1'b0, !h} : {1'b1, h};
        dcol     = r_phase ? {1'b0, h} : {1'b1, !h};
        case (r_state)
            S_MINOR: begin
                a_op       = $signed(i_job[ri][{r_phase, 1'b0}]);
                b_op       = 33'($signed(i_job[rj][{r_phase, 1'b1}]));
                ctl0.valid = 1'b1;
                ctl0.first = !r_part;
                ctl0.last  = r_part;
                ctl0.neg   = r_part;
                ctl0.kind  = K_MINOR;
                ctl0.didx  = {1'b0, r_idx};
            end
            S_COF: begin
                a_op       = $signed(i_job[term.erow][ecol]);
                bw         = r_minor[term.midx];
                b_op       = r_part ? 33'($signed(bw[63:32])) : $signed({1'b0, bw[31:0]});
                ctl0.valid = 1'b1;
                ctl0.first = (r_term == 2'd0) && !r_part;
                ctl0.last  = (r_term == 2'd2) && r_part;
                ctl0.hi    = r_part;
                ctl0.neg   = term.neg ^ r_phase ^ h;
                ctl0.kind  = K_COF;
                ctl0.didx  = {2'd3 - k, dcol};
            end
            S_DET: begin
                cof_addr   = {k, 2'd0};
                a_op       = $signed(i_job[k][0]);
                bw         = cof_rd;
                b_op       = r_part ? 33'($signed(bw[63:32])) : $signed({1'b0, bw[31:0]});
                ctl0.valid = 1'b1;
                ctl0.first = (k == 2'd0) && !r_part;
                ctl0.last  = (k == 2'd3) && r_part;
                ctl0.hi    = r_part;
                ctl0.kind  = K_DET;
            end
            default: begin
                ctl0 = '0;
            end
        endcase
    end

    assign cof_rd = r_cof[cof_addr];

    // accumulate stage
    logic signed [AW-1:0] term_ext;
    logic signed [AW-1:0] n_acc;

    always_comb begin
        term_ext = AW'(r_prod);
        if (r_ctl1.hi) begin
            term_ext = term_ext <<< 32;
        end
        n_acc = r_ctl1.first ? '0 : r_acc;
        n_acc = r_ctl1.neg ? n_acc - term_ext : n_acc + term_ext;
    end

    // write-back rounding
    logic signed [AW-1:0] cof_rnd;
    logic signed [AW-1:0] cof_sh;
    logic [63:0]          cof_sat;
    logic signed [AW-1:0] det_rnd;

    always_comb begin
        cof_rnd = r_acc + (AW'(1) <<< (2 * FRAC_BITS - 1));
        cof_sh  = cof_rnd >>> (2 * FRAC_BITS);
        if ((&cof_sh[AW-1:63]) || !(|cof_sh[AW-1:63])) begin
            cof_sat = cof_sh[63:0];
        end else begin
            cof_sat = cof_sh[AW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        det_rnd = (r_acc + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end

    // divider operands and result
    logic [63:0]    cm;
    logic           cn;
    logic [DVW-1:0] num;
    logic           ge;
    logic [31:0]    qsat;
    logic [31:0]    detsat;
    logic           slot_free;

    always_comb begin
        cn  = cof_rd[63];
        cm  = cn ? (64'd0 - cof_rd) : cof_rd;
        num = (DVW'(cm) << (FRAC_BITS + 1)) + DVW'(r_dmag);
        ge  = (r_rem >= r_dsh);
        if (r_qneg) begin
            qsat = (r_q > QW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'd0 - r_q[31:0];
        end else begin
            qsat = (r_q > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_q[31:0];
        end
        if ((&r_det[AW-1:31]) || !(|r_det[AW-1:31])) begin
            detsat = r_det[31:0];
        end else begin
            detsat = r_det[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    assign slot_free = !r_ovalid || i_pop;
    assign o_q_pop   = (r_state == S_EMIT) && slot_free && (r_row == 2'd3);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_phase  <= 1'b0;
            r_idx    <= '0;
            r_term   <= '0;
            r_part   <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
            r_it     <= '0;
            r_ctl1   <= '0;
            r_ctl2   <= '0;
            r_ovalid <= 1'b0;
            r_eps    <= 31'd1;
            r_fill   <= 32'h7FFF_FFFF;
        end else begin
            r_ctl1 <= ctl0;
            r_ctl2 <= r_ctl1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EPSILON: r_eps  <= i_cfg_wdata[30:0];
                    CFG_FILL:    r_fill <= i_cfg_wdata;
                    default:     r_fill <= r_fill;
                endcase
            end
            if (i_pop && r_ovalid && !((r_state == S_EMIT) && slot_free)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_phase <= 1'b0;
                        r_idx   <= '0;
                        r_term  <= '0;
                        r_part  <= 1'b0;
                        r_state <= S_MINOR;
                    end
                end
                S_MINOR: begin
                    r_part <= !r_part;
                    if (r_part) begin
                        if (r_idx == 3'd5) begin
                            r_idx   <= '0;
                            r_ret   <= S_COF;
                            r_state <= S_DRAIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_COF: begin
                    r_part <= !r_part;
                    if (r_part) begin
                        if (r_term == 2'd2) begin
                            r_term <= '0;
                            if (r_idx == 3'd7) begin
                                r_idx   <= '0;
                                r_phase <= !r_phase;
                                r_ret   <= r_phase ? S_DET : S_MINOR;
                                r_state <= S_DRAIN;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end else begin
                            r_term <= r_term + 1'b1;
                        end
                    end
                end
                S_DET: begin
                    r_part <= !r_part;
                    if (r_part) begin
                        if (r_idx == 3'd3) begin
                            r_idx   <= '0;
                            r_ret   <= S_CHECK;
                            r_state <= S_DRAIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    // wait until the last product is written back
                    if (!r_ctl1.valid && !r_ctl2.valid) begin
                        r_state <= r_ret;
                    end
                end
                S_CHECK: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_state <= (r_dmag <= AW'(r_eps)) ? S_EMIT : S_DIVLD;
                end
                S_DIVLD: begin
                    r_it    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_it <= r_it + 1'b1;
                    if (r_it == 6'(QW - 1)) begin
                        r_state <= S_DIVWB;
                    end
                end
                S_DIVWB: begin
                    if (r_col == 2'd3) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_DIVLD;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        if (r_row == 2'd3) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_col   <= '0;
                            r_state <= r_sing ? S_EMIT : S_DIVLD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 65'(a_op) * 65'(b_op);
        r_acc  <= n_acc;
        if (r_ctl2.valid && r_ctl2.last) begin
            case (r_ctl2.kind)
                K_MINOR: r_minor[r_ctl2.didx[2:0]] <= r_acc[63:0];
                K_COF:   r_cof[r_ctl2.didx]        <= cof_sat;
                K_DET:   r_det                     <= det_rnd;
                default: r_det                     <= r_det;
            endcase
        end
        case (r_state)
            S_CHECK: begin
                r_dneg <= r_det[AW-1];
                r_dmag <= r_det[AW-1] ? AW'(-r_det) : AW'(r_det);
                r_detf <= detsat;
            end
            S_DECIDE: begin
                r_sing <= (r_dmag <= AW'(r_eps));
            end
            S_DIVLD: begin
                // divisor is 2 * dmag aligned to quotient bit QW-1
                r_rem  <= num;
                r_dsh  <= DVW'(r_dmag) << QW;
                r_q    <= '0;
                r_qneg <= cn ^ r_dneg;
            end
            S_DIV: begin
                // one restoring step; a set top bit means the result saturates
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= {r_q[QW-2:0], ge};
            end
            S_DIVWB: begin
                r_rowv[r_col] <= qsat;
            end
            S_EMIT: begin
                if (slot_free) begin
                    r_orow  <= r_row;
                    r_odet  <= r_detf;
                    r_osing <= r_sing;
                    r_olast <= (r_row == 2'd3);
                    for (int j = 0; j < 4; j++) begin
                        if (r_sing) begin
                            if (2'(j) != r_row) begin
                                r_ov[j] <= '0;
                            end else if (r_row == 2'd3) begin
                                r_ov[j] <= 32'(1) << FRAC_BITS;
                            end else begin
                                r_ov[j] <= r_fill;
                            end
                        end else begin
                            r_ov[j] <= r_rowv[j];
                        end
                    end
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_empty       = !r_ovalid;
    assign o_out_row     = r_orow;
    assign o_inv0        = r_ov[0];
    assign o_inv1        = r_ov[1];
    assign o_inv2        = r_ov[2];
    assign o_inv3        = r_ov[3];
    assign o_determinant = r_odet;
    assign o_singular    = r_osing;
    assign o_last        = r_olast;

endmodule

/* src/matrix4_inverse_unit.sv */
// 4x4 fixed-point matrix inverse, usage
// input queue side: push/full carry one matrix row per item (row_index,
// elem0..3, last_row). a row is taken unless full is set, and kept in the store;
// the item with last_row set snapshots the matrix into a two-entry job queue,
// so rows of the next matrix can be taken while the current one is inverted.
// result queue side: empty/pop; four items per matrix, out_row 0..3, last on
// row 3, each with the determinant and the singular flag.
// after the last row is taken, the back end starts, runs the multiply-accumulate
// schedule (128 products on one 32x33 multiplier, pipeline drains, determinant
// check), then the four restoring divisions of row 0, and loads the result
// register with the first result; a singular matrix skips the divisions.
// the divider, one quotient bit a cycle, sets the throughput.
// the user writes epsilon and singular_fill on the cfg port only while idle (not enforced).
// reset clears the queues and the control registers (epsilon 1, fill max positive).
// when pop stays low the finished row waits in the result register and the
// back end holds; the front keeps taking rows until the job queue is full.
`include "assert_macros.svh"
module matrix4_inverse_unit #(
    parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_row_index,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem0,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem1,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem2,
    input  logic [mi4_pkg::ELEM_W-1:0]  i_elem3,
    input  logic                        i_last_row,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_out_row,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv0,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv1,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv2,
    output logic [mi4_pkg::ELEM_W-1:0]  o_inv3,
    output logic [mi4_pkg::ELEM_W-1:0]  o_determinant,
    output logic                        o_singular,
    output logic                        o_last
);
    import mi4_pkg::*;

    t_jobq_wr q_wr;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    t_mat     q_head;

    mi4_front u_front (
        .i_clk       (i_clk),
        .i_push      (push),
        .i_q_full    (q_full),
        .i_row_index (i_row_index),
        .i_elem0     (i_elem0),
        .i_elem1     (i_elem1),
        .i_elem2     (i_elem2),
        .i_elem3     (i_elem3),
        .i_last_row  (i_last_row),
        .o_full      (full),
        .o_wr        (q_wr)
    );

    mi4_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    mi4_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_empty     (q_empty),
        .i_job         (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_row     (o_out_row),
        .o_inv0        (o_inv0),
        .o_inv1        (o_inv1),
        .o_inv2        (o_inv2),
        .o_inv3        (o_inv3),
        .o_determinant (o_determinant),
        .o_singular    (o_singular),
        .o_last        (o_last)
    );

    `MI4_ASSERT(a_no_push_full, i_clk, i_rst_n, !(q_wr.push && q_full))
    `MI4_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(q_pop && q_empty))
    `MI4_ASSERT(a_last_row3, i_clk, i_rst_n, (!empty && o_last) |-> (o_out_row == 2'd3))
    `MI4_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> (empty && !full))

endmodule

/* verif/tb_matrix4_inverse_unit.sv */
// testbench for matrix4_inverse_unit: rows are pushed, inverses popped and compared
// against a cofactor-based predictor kept in the bench; depends on mi4_pkg
`timescale 1ns / 1ps

module tb_matrix4_inverse_unit;

    localparam int FRAC = mi4_pkg::FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] elem[4];
        logic        last_row;
    } t_row_item;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] inv[4];
        logic [31:0] det;
        logic        singular;
        logic        last;
    } t_inv_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        push;
    logic        full;
    logic [1:0]  i_row_index;
    logic [31:0] i_elem0, i_elem1, i_elem2, i_elem3;
    logic        i_last_row;
    logic        empty;
    logic        pop;
    logic [1:0]  o_out_row;
    logic [31:0] o_inv0, o_inv1, o_inv2, o_inv3, o_determinant;
    logic        o_singular, o_last;

    matrix4_inverse_unit dut (.*);

    t_row_item   pending_rows[$];
    t_inv_row    expected_rows[$];
    logic signed [63:0] held_mat[4][4];
    logic [30:0] epsilon_reg;
    logic [31:0] fill_reg;
    int          send_idle_pct, recv_idle_pct;
    int          errors;
    int          stall_cycles;
    int          hold_left;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exact 2x2 minor, wrapped to 64 bits
    function automatic logic signed [63:0] minor2(int i, int j, int ca, int cb);
        t_wide t;
        t = t_wide'(held_mat[i][ca]) * t_wide'(held_mat[j][cb])
          - t_wide'(held_mat[j][ca]) * t_wide'(held_mat[i][cb]);
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] cofactor3(
        logic signed [63:0] a1, logic signed [63:0] b1,
        logic signed [63:0] a2, logic signed [63:0] b2,
        logic signed [63:0] a3, logic signed [63:0] b3, bit plus3);
        t_wide t;
        t_wide t3;
        t3 = t_wide'(a3) * t_wide'(b3);
        t = t_wide'(a1) * t_wide'(b1) - t_wide'(a2) * t_wide'(b2);
        t = plus3 ? t + t3 : t - t3;
        t = (t + (t_wide'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
        if (t > t_wide'(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (t < -t_wide'(64'sh7FFF_FFFF_FFFF_FFFF) - 1) return 64'sh8000_0000_0000_0000;
        return t[63:0];
    endfunction

    function automatic logic [31:0] clamp32(t_wide v);
        if (v > t_wide'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (v < -t_wide'(32'sh8000_0000) - 1 + 1 && v < t_wide'(-64'sd2147483648))
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // cofactor expansion of the held matrix; queues the four inverse rows
    task automatic predict_inverse();
        logic signed [63:0] c[4][4];
        logic signed [63:0] e[4][4];
        logic signed [63:0] s01, s02, s03, s12, s13, s23;
        t_wide acc, d, dmag, cm, num, den, q;
        bit sing;
        t_inv_row r;
        e = held_mat;
        s01 = minor2(0, 1, 0, 1); s02 = minor2(0, 2, 0, 1); s03 = minor2(0, 3, 0, 1);
        s12 = minor2(1, 2, 0, 1); s13 = minor2(1, 3, 0, 1); s23 = minor2(2, 3, 0, 1);
        c[3][3] = cofactor3(e[0][2], s12, e[1][2], s02, e[2][2], s01, 1);
        c[2][3] = cofactor3(e[1][2], s03, e[3][2], s01, e[0][2], s13, 0);
        c[1][3] = cofactor3(e[0][2], s23, e[2][2], s03, e[3][2], s02, 1);
        c[0][3] = cofactor3(e[2][2], s13, e[3][2], s12, e[1][2], s23, 0);
        c[3][2] = cofactor3(e[1][3], s02, e[2][3], s01, e[0][3], s12, 0);
        c[2][2] = cofactor3(e[0][3], s13, e[1][3], s03, e[3][3], s01, 1);
        c[1][2] = cofactor3(e[2][3], s03, e[3][3], s02, e[0][3], s23, 0);
        c[0][2] = cofactor3(e[1][3], s23, e[2][3], s13, e[3][3], s12, 1);
        s01 = minor2(0, 1, 2, 3); s02 = minor2(0, 2, 2, 3); s03 = minor2(0, 3, 2, 3);
        s12 = minor2(1, 2, 2, 3); s13 = minor2(1, 3, 2, 3); s23 = minor2(2, 3, 2, 3);
        c[3][0] = cofactor3(e[1][1], s02, e[2][1], s01, e[0][1], s12, 0);
        c[2][0] = cofactor3(e[0][1], s13, e[1][1], s03, e[3][1], s01, 1);
        c[1][0] = cofactor3(e[2][1], s03, e[3][1], s02, e[0][1], s23, 0);
        c[0][0] = cofactor3(e[1][1], s23, e[2][1], s13, e[3][1], s12, 1);
        c[3][1] = cofactor3(e[0][0], s12, e[1][0], s02, e[2][0], s01, 1);
        c[2][1] = cofactor3(e[1][0], s03, e[3][0], s01, e[0][0], s13, 0);
        c[1][1] = cofactor3(e[0][0], s23, e[2][0], s03, e[3][0], s02, 1);
        c[0][1] = cofactor3(e[2][0], s13, e[3][0], s12, e[1][0], s23, 0);
        acc = 0;
        for (int k = 0; k < 4; k++) acc += t_wide'(e[k][0]) * t_wide'(c[k][0]);
        d = (acc + (t_wide'(1) <<< (FRAC - 1))) >>> FRAC;
        dmag = (d < 0) ? -d : d;
        sing = (dmag <= t_wide'({97'd0, epsilon_reg}));
        for (int k = 0; k < 4; k++) begin
            r.row = k[1:0];
            for (int j = 0; j < 4; j++) begin
                if (sing) begin
                    r.inv[j] = (j != k) ? 32'd0 : (k < 3) ? fill_reg : 32'd1 << FRAC;
                end else begin
                    cm = t_wide'(c[j][k]);
                    if (cm < 0) cm = -cm;
                    num = (cm <<< (FRAC + 1)) + dmag;
                    den = dmag <<< 1;
                    q = num / den;
                    if ((c[j][k] < 0) != (d < 0)) q = -q;
                    r.inv[j] = clamp32(q);
                end
            end
            r.det = clamp32(d);
            r.singular = sing;
            r.last = (k == 3);
            expected_rows.push_back(r);
        end
    endtask

    // driver: presents queued rows, records each accepted item, predicts on each accepted last row
    always @(posedge i_clk) begin
        t_row_item it;
        logic next_push;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            next_push = push;
            if (push && !full) begin
                held_mat[i_row_index][0] = 64'(signed'(i_elem0));
                held_mat[i_row_index][1] = 64'(signed'(i_elem1));
                held_mat[i_row_index][2] = 64'(signed'(i_elem2));
                held_mat[i_row_index][3] = 64'(signed'(i_elem3));
                if (i_last_row) predict_inverse();
                next_push = 1'b0;
            end
            if (!next_push && pending_rows.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                it = pending_rows.pop_front();
                i_row_index <= it.row;
                i_elem0 <= it.elem[0];
                i_elem1 <= it.elem[1];
                i_elem2 <= it.elem[2];
                i_elem3 <= it.elem[3];
                i_last_row <= it.last_row;
                next_push = 1'b1;
            end
            push <= next_push;
        end
    end

    // monitor: pops result rows and checks them against the oldest prediction
    always @(posedge i_clk) begin
        t_inv_row x;
        logic [31:0] got[4];
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_left = 0;
        end else begin
            if (pop && !empty) begin
                got = '{o_inv0, o_inv1, o_inv2, o_inv3};
                if (expected_rows.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result row %0d", $time, o_out_row);
                end else begin
                    x = expected_rows.pop_front();
                    if (o_out_row !== x.row) begin
                        errors++;
                        $display("%0t: out_row exp %0d got %0d", $time, x.row, o_out_row);
                    end
                    for (int j = 0; j < 4; j++)
                        if (got[j] !== x.inv[j]) begin
                            errors++;
                            $display("%0t: row %0d inv%0d exp %h got %h",
                                     $time, x.row, j, x.inv[j], got[j]);
                        end
                    if (o_determinant !== x.det) begin
                        errors++;
                        $display("%0t: determinant exp %h got %h", $time, x.det,
                                 o_determinant);
                    end
                    if (o_singular !== x.singular) begin
                        errors++;
                        $display("%0t: singular exp %b got %b", $time, x.singular,
                                 o_singular);
                    end
                    if (o_last !== x.last) begin
                        errors++;
                        $display("%0t: last exp %b got %b", $time, x.last, o_last);
                    end
                end
            end
            if (hold_request) begin
                hold_request = 0;
                hold_left = 4000;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx == mi4_pkg::CFG_EPSILON) epsilon_reg = val[30:0];
        else fill_reg = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_row(int r, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, bit lst);
        t_row_item it;
        it.row = r[1:0];
        it.elem = '{a, b, c, d};
        it.last_row = lst;
        pending_rows.push_back(it);
    endtask

    function automatic logic [31:0] rand_elem(int mode);
        if (mode == 0) return 32'($urandom_range(524288)) - 32'd262144;
        return $urandom;
    endfunction

    // one random matrix or fragment; mostly complete matrices in shuffled row order
    task automatic add_random_matrix();
        int order[4] = '{0, 1, 2, 3};
        int kind, mode, n;
        logic [31:0] dup[4];
        kind = $urandom_range(9);
        mode = (kind == 6) ? 1 : 0;
        order.shuffle();
        if (kind <= 7) begin
            for (int k = 0; k < 4; k++) dup[k] = rand_elem(mode);
            for (int i = 0; i < 4; i++) begin
                if (kind == 7 && i >= 2)
                    add_row(order[i], dup[0], dup[1], dup[2], dup[3], i == 3);
                else if (kind == 7)
                    add_row(order[i], dup[0], dup[1], dup[2], dup[3], 0);
                else
                    add_row(order[i], rand_elem(mode), rand_elem(mode), rand_elem(mode),
                            rand_elem(mode), i == 3);
            end
        end else if (kind == 8) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                add_row(order[i], rand_elem(0), rand_elem(1), rand_elem(0), rand_elem(0),
                        i == n - 1);
        end else begin
            add_row($urandom_range(3), rand_elem(1), rand_elem(1), rand_elem(1),
                    rand_elem(1), $urandom_range(1));
        end
    endtask

    task automatic drain_and_settle();
        while (pending_rows.size() > 0 || push || expected_rows.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic run_random(int n_items);
        int target;
        target = n_items;
        while (target > 0) begin
            add_random_matrix();
            target -= 4;
        end
    endtask

    localparam logic [31:0] ONE = 32'd1 << FRAC;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = mi4_pkg::CFG_EPSILON;
        i_cfg_wdata = '0;
        i_row_index = '0;
        {i_elem0, i_elem1, i_elem2, i_elem3} = '0;
        i_last_row = 1'b0;
        epsilon_reg = 31'd1;
        fill_reg = PMAX;
        errors = 0;
        stall_cycles = 0;
        hold_request = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (held_mat[i, j]) held_mat[i][j] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, out-of-order rows, extremes, zero and rank-deficient
        add_row(3, 0, 0, 0, ONE, 0);
        add_row(1, 0, ONE, 0, 0, 0);
        add_row(0, ONE, 0, 0, 0, 0);
        add_row(2, 0, 0, ONE, 0, 1);
        add_row(0, PMAX, 0, 0, 0, 1);
        add_row(1, 0, NMIN, 0, 0, 1);
        add_row(2, 0, 0, 32'h0000_0100, 0, 0);
        add_row(3, 0, 0, 0, 32'hFFFF_0000, 1);
        add_row(0, 32'd0, 32'd0, 32'd0, 32'd0, 1);
        add_row(0, PMAX, PMAX, PMAX, PMAX, 0);
        add_row(1, NMIN, NMIN, NMIN, NMIN, 0);
        add_row(2, PMAX, NMIN, PMAX, NMIN, 0);
        add_row(3, NMIN, PMAX, NMIN, PMAX, 1);
        add_row(0, ONE, 32'h0002_0000, 0, 0, 0);
        add_row(1, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0);
        add_row(2, 0, 0, 32'h0000_8000, ONE, 0);
        add_row(3, 0, 0, ONE, 32'hFFFF_8000, 1);
        add_row(1, 32'hFFFF_FFFF, 32'd1, 32'h5555_5555, 32'hAAAA_AAAA, 1);
        drain_and_settle();

        write_reg(mi4_pkg::CFG_EPSILON, 32'd0);
        write_reg(mi4_pkg::CFG_FILL, NMIN);
        send_idle_pct = 16;
        recv_idle_pct = 59;
        add_row(0, 0, 0, 0, 0, 1);
        run_random(120);
        drain_and_settle();

        write_reg(mi4_pkg::CFG_EPSILON, 32'h7FFF_FFFF);
        write_reg(mi4_pkg::CFG_FILL, $urandom);
        send_idle_pct = 59;
        recv_idle_pct = 16;
        run_random(120);
        drain_and_settle();

        write_reg(mi4_pkg::CFG_EPSILON, 32'h0000_1000);
        write_reg(mi4_pkg::CFG_FILL, PMAX);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        run_random(120);
        drain_and_settle();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
